// File: rtl/selsc_pkg.sv
// Shared types and constants of the spectral energy log scaler.
// No dependencies; every other file of the block imports this package.
package selsc_pkg;

    localparam int unsigned IN_W     = 22;   // energy field width
    localparam int unsigned V_W      = 16;   // energy after the input shift
    localparam int unsigned SHIFT_IN = 6;
    localparam int unsigned IP_W     = 4;    // integer part of the Q4.12 log
    localparam int unsigned FRAC_W   = 12;   // kept fraction bits
    localparam int unsigned LOG_W    = IP_W + FRAC_W;
    localparam int unsigned OUT_W    = 17;
    localparam int unsigned PROD_W   = 32;   // value times scale
    localparam int unsigned Y_W      = 27;   // product with the divisor's power of two removed
    localparam int unsigned RECIP_W  = 17;
    localparam int unsigned ACC_W    = Y_W + RECIP_W;
    localparam int unsigned ODD_W    = 11;

    // 64000 = 2^9 * 125, 60000 = 2^5 * 1875
    localparam int unsigned LOG_DIV_SHIFT   = 9;
    localparam int unsigned LIN_DIV_SHIFT   = 5;
    localparam logic [ODD_W-1:0]   LOG_DIV_ODD = 11'd125;
    localparam logic [ODD_W-1:0]   LIN_DIV_ODD = 11'd1875;
    // floor(2^23 / 125) and floor(2^27 / 1875)
    localparam logic [RECIP_W-1:0] LOG_RECIP   = 17'd67108;
    localparam logic [RECIP_W-1:0] LIN_RECIP   = 17'd71582;

    typedef enum logic [1:0] {
        REG_OUT_SCALE   = 2'd0,
        REG_FLOOR_LEVEL = 2'd1,
        REG_LOG_MODE    = 2'd2
    } t_reg_idx;

    // Beat inside the squaring chain: mantissa normalized so that its
    // leading one sits at bit 15, mask clears the bits below Q[ip].
    typedef struct packed {
        logic [V_W-1:0]    mant;
        logic [V_W-1:0]    mask;
        logic [IP_W-1:0]   ip;
        logic [FRAC_W-1:0] frac;
        logic              zero;
        logic [V_W-1:0]    v;
    } t_sq_beat;

    // Beat leaving the logarithm unit.
    typedef struct packed {
        logic [LOG_W-1:0] lg;
        logic [V_W-1:0]   v;
    } t_lvl_beat;

endpackage

// File: rtl/selsc_sq_stage.sv
// One repeated-squaring stage of the binary logarithm: yields one fraction bit.
// Depends on selsc_pkg.
module selsc_sq_stage #(
    parameter int unsigned BIT_POS = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  selsc_pkg::t_sq_beat i_beat,
    output logic                o_valid,
    input  logic                i_ready,
    output selsc_pkg::t_sq_beat o_beat
);
    import selsc_pkg::*;

    logic [2*V_W-1:0] w_sq;
    logic [V_W:0]     w_trunc;
    t_sq_beat         n_beat;
    logic             r_valid;
    t_sq_beat         r_beat;

    // Square, drop back to Q[ip], renormalize when the square reaches two.
    always_comb begin
        w_sq    = {{V_W{1'b0}}, i_beat.mant} * {{V_W{1'b0}}, i_beat.mant};
        w_trunc = w_sq[2*V_W-1:V_W-1] & {1'b1, i_beat.mask};
        n_beat  = i_beat;
        if (w_trunc[V_W]) begin
            n_beat.mant          = w_trunc[V_W:1] & i_beat.mask;
            n_beat.frac[BIT_POS] = 1'b1;
        end else begin
            n_beat.mant = w_trunc[V_W-1:0];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// File: rtl/selsc_log2.sv
// Floor removal, leading-one normalize and twelve squaring stages: Q4.12 log2.
// Depends on selsc_pkg and selsc_sq_stage.
module selsc_log2 (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [selsc_pkg::V_W-1:0] i_v,
    input  logic [selsc_pkg::V_W-1:0] i_floor_level,
    output logic                     o_valid,
    input  logic                     i_ready,
    output selsc_pkg::t_lvl_beat     o_beat
);
    import selsc_pkg::*;

    // floor removal stage
    logic           r_f_valid;
    logic [V_W-1:0] r_f_d;
    logic [V_W-1:0] r_f_v;
    logic           w_f_ready;
    // normalize stage
    logic           r_n_valid;
    t_sq_beat       r_n_beat;
    logic           w_n_ready;
    t_sq_beat       n_norm;
    logic [IP_W-1:0] w_ip;
    logic [IP_W-1:0] w_k;

    logic     w_valid [FRAC_W+1];
    logic     w_ready [FRAC_W+1];
    t_sq_beat w_beat  [FRAC_W+1];

    assign o_ready   = !r_f_valid || w_f_ready;
    assign w_f_ready = !r_n_valid || w_n_ready;
    assign w_n_ready = w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_n_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_f_valid <= i_valid;
            end
            if (w_f_ready) begin
                r_n_valid <= r_f_valid;
            end
        end
    end

    // Leading one and left shift to put it at bit 15.
    always_comb begin
        w_ip = '0;
        for (int i = 0; i < V_W; i++) begin
            if (r_f_d[i]) begin
                w_ip = IP_W'(i);
            end
        end
        w_k         = IP_W'(V_W - 1) - w_ip;
        n_norm.mant = r_f_d << w_k;
        n_norm.mask = {V_W{1'b1}} << w_k;
        n_norm.ip   = w_ip;
        n_norm.frac = '0;
        n_norm.zero = (r_f_d == '0);
        n_norm.v    = r_f_v;
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_f_d <= (i_v < i_floor_level) ? '0 : i_v - i_floor_level;
            r_f_v <= i_v;
        end
        if (w_f_ready && r_f_valid) begin
            r_n_beat <= n_norm;
        end
    end

    assign w_valid[0] = r_n_valid;
    assign w_beat[0]  = r_n_beat;

    for (genvar g = 0; g < FRAC_W; g++) begin : g_sq
        selsc_sq_stage #(
            .BIT_POS (FRAC_W - 1 - g)
        ) u_sq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    assign w_ready[FRAC_W] = i_ready;
    assign o_valid         = w_valid[FRAC_W];
    assign o_beat.lg       = w_beat[FRAC_W].zero ? '0
                           : {w_beat[FRAC_W].ip, w_beat[FRAC_W].frac};
    assign o_beat.v        = w_beat[FRAC_W].v;

endmodule

// File: rtl/selsc_scale_div.sv
// Scale multiply and exact division by 64000 or 60000 through a reciprocal.
// Depends on selsc_pkg.
module selsc_scale_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  selsc_pkg::t_lvl_beat       i_beat,
    input  logic [selsc_pkg::V_W-1:0]  i_out_scale,
    input  logic                       i_lin,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [selsc_pkg::OUT_W-1:0] o_level
);
    import selsc_pkg::*;

    logic              r_m_valid, r_a_valid, r_b_valid, r_c_valid;
    logic              w_m_ready, w_a_ready, w_b_ready, w_c_ready;
    logic [PROD_W-1:0] r_m_x;
    logic              r_m_lin, r_a_lin, r_b_lin;
    logic [ACC_W-1:0]  r_a_prod;
    logic [Y_W-1:0]    r_a_y, r_b_y;
    logic [OUT_W-1:0]  r_b_q0;
    logic [Y_W-1:0]    r_b_qc;
    logic [OUT_W-1:0]  r_c_level;

    logic [V_W-1:0]     w_mul_in;
    logic [Y_W-1:0]     w_y;
    logic [RECIP_W-1:0] w_recip;
    logic [OUT_W-1:0]   w_q0;
    logic [ODD_W-1:0]   w_b_odd;
    logic [ODD_W-1:0]   w_c_odd;
    logic [Y_W-1:0]     w_rem;
    logic               w_corr;

    assign w_c_ready = !r_c_valid || i_ready;
    assign w_b_ready = !r_b_valid || w_c_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign w_m_ready = !r_m_valid || w_a_ready;
    assign o_ready   = w_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_m_ready) r_m_valid <= i_valid;
            if (w_a_ready) r_a_valid <= r_m_valid;
            if (w_b_ready) r_b_valid <= r_a_valid;
            if (w_c_ready) r_c_valid <= r_b_valid;
        end
    end

    always_comb begin
        w_mul_in = i_lin ? i_beat.v : i_beat.lg;
        // strip the divisor's power of two, then multiply by the odd part's reciprocal
        w_y      = r_m_lin ? r_m_x[PROD_W-1:LIN_DIV_SHIFT]
                           : {{(LOG_DIV_SHIFT-LIN_DIV_SHIFT){1'b0}},
                              r_m_x[PROD_W-1:LOG_DIV_SHIFT]};
        w_recip  = r_m_lin ? LIN_RECIP : LOG_RECIP;
        w_q0     = r_a_lin ? r_a_prod[ACC_W-1:Y_W]
                           : r_a_prod[ACC_W-1-(LOG_DIV_SHIFT-LIN_DIV_SHIFT):
                                      Y_W-(LOG_DIV_SHIFT-LIN_DIV_SHIFT)];
        w_b_odd  = r_a_lin ? LIN_DIV_ODD : LOG_DIV_ODD;
        // the estimate is low by at most one
        w_c_odd  = r_b_lin ? LIN_DIV_ODD : LOG_DIV_ODD;
        w_rem    = r_b_y - r_b_qc;
        w_corr   = (w_rem >= {{(Y_W-ODD_W){1'b0}}, w_c_odd});
    end

    always_ff @(posedge i_clk) begin
        if (w_m_ready && i_valid) begin
            r_m_x   <= {{V_W{1'b0}}, w_mul_in} * {{V_W{1'b0}}, i_out_scale};
            r_m_lin <= i_lin;
        end
        if (w_a_ready && r_m_valid) begin
            r_a_prod <= {{RECIP_W{1'b0}}, w_y} * {{Y_W{1'b0}}, w_recip};
            r_a_y    <= w_y;
            r_a_lin  <= r_m_lin;
        end
        if (w_b_ready && r_a_valid) begin
            r_b_q0  <= w_q0;
            r_b_qc  <= Y_W'({{(Y_W-OUT_W){1'b0}}, w_q0} * {{(Y_W-ODD_W){1'b0}}, w_b_odd});
            r_b_y   <= r_a_y;
            r_b_lin <= r_a_lin;
        end
        if (w_c_ready && r_b_valid) begin
            r_c_level <= r_b_q0 + {{(OUT_W-1){1'b0}}, w_corr};
        end
    end

    assign o_valid = r_c_valid;
    assign o_level = r_c_level;

endmodule

// File: rtl/spectral_energy_log_scaler_core.sv
// Top level of the spectral energy log scaler: register port, input stage and pipeline.
// Depends on selsc_pkg, selsc_log2 (with selsc_sq_stage) and selsc_scale_div.
//
// Maps one 22-bit high-frequency-content energy beat to a 17-bit brightness
// level. The energy is shifted right by 6. In log mode (log_mode = 0) the
// noise floor is subtracted with saturation at zero, a Q4.12 base-2 log is
// taken (leading one for the integer part, twelve squaring steps for the
// fraction, zero maps to zero) and the level is log * out_scale / 64000.
// In linear mode the level is value * out_scale / 60000. All divisions
// truncate. The block takes one beat per clock while the output is not
// stalled and delivers one result per beat. The pipeline is one input
// register, floor removal, normalize, twelve squaring stages (one 16x16
// multiplier each), the scale multiply and three stages of reciprocal
// division. Every stage holds its own valid bit, so a stalled output only
// backs up as far as the pipeline is full. Registers sit on an APB port at
// byte addresses 0 (out_scale), 4 (floor_level) and 8 (log_mode); change
// them only while the pipeline is empty.
module spectral_energy_log_scaler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [21:0] hfc_energy, [23:22] zero
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] level_out, [23:17] zero
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import selsc_pkg::*;

    logic [V_W-1:0]   r_out_scale;
    logic [V_W-1:0]   r_floor_level;
    logic             r_log_mode;
    t_reg_idx         w_idx;
    logic             w_wr;

    logic             r_in_valid;
    logic [V_W-1:0]   r_in_v;
    logic             w_log_ready;
    logic             w_lvl_valid;
    logic             w_lvl_ready;
    t_lvl_beat        w_lvl_beat;
    logic [OUT_W-1:0] w_level;

    // Register port: no wait states, write on the access cycle.
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_scale   <= 16'd255;
            r_floor_level <= '0;
            r_log_mode    <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_OUT_SCALE: begin
                    r_out_scale <= pwdata[V_W-1:0];
                end
                REG_FLOOR_LEVEL: begin
                    r_floor_level <= pwdata[V_W-1:0];
                end
                REG_LOG_MODE: begin
                    r_log_mode <= pwdata[0];
                end
                default: begin
                    // unmapped address: drop the write
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_OUT_SCALE:   prdata = {16'd0, r_out_scale};
            REG_FLOOR_LEVEL: prdata = {16'd0, r_floor_level};
            REG_LOG_MODE:    prdata = {31'd0, r_log_mode};
            default:         prdata = '0;
        endcase
    end

    // Input stage: take the beat and drop the six low bits.
    assign s_axis_tready = !r_in_valid || w_log_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_v <= s_axis_tdata[IN_W-1:SHIFT_IN];
        end
    end

    selsc_log2 u_log2 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .o_ready       (w_log_ready),
        .i_v           (r_in_v),
        .i_floor_level (r_floor_level),
        .o_valid       (w_lvl_valid),
        .i_ready       (w_lvl_ready),
        .o_beat        (w_lvl_beat)
    );

    // The last divider stage is the output register.
    selsc_scale_div u_scale_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_lvl_valid),
        .o_ready     (w_lvl_ready),
        .i_beat      (w_lvl_beat),
        .i_out_scale (r_out_scale),
        .i_lin       (r_log_mode),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_level     (w_level)
    );

    assign m_axis_tdata = {{(24-OUT_W){1'b0}}, w_level};

endmodule
